/* rtl/core/sfe_pkg.sv */
// Shared types and constants for the stereo feedforward echo block.
// No dependencies; every other file of the block refers to it by scoped names.
package sfe_pkg;

    // Sample and gain formats
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int SCALED_W    = PROD_W - GAIN_FRAC;
    localparam int DELAY_W     = 16;
    localparam int PAIR_W      = 2 * SAMPLE_W;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]          gain_t;
    typedef logic [DELAY_W-1:0]         delay_t;
    typedef logic [PROD_W-1:0]          prod_t;
    typedef logic [SCALED_W-1:0]        scaled_t;
    typedef logic [PAIR_W-1:0]          pair_t;

    // Saturation bounds of the scaled echo
    localparam sample_t SAT_POS = 16'sh7fff;
    localparam sample_t SAT_NEG = 16'sh8000;
    localparam scaled_t NEG_LIMIT = scaled_t'(32768);
    localparam scaled_t POS_LIMIT = scaled_t'(32767);

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_SAMPLES = 4'd0,
        REG_ECHO_GAIN     = 4'd1
    } cfg_reg_t;

    // How the delayed sample is sourced for one beat
    typedef struct packed {
        logic zero_delay;  // echo the current sample
        logic hit;         // history entry was written since reset
    } echo_tap_t;

    // Load strobes for the two arithmetic stages
    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } stage_ctl_t;

endpackage

/* rtl/core/sfe_if.sv */
// Valid/ready channel interfaces: sample input, result output, register write.
// Depends on sfe_pkg for payload types.
interface sfe_sample_if;
    logic            valid;
    logic            ready;
    sfe_pkg::sample_t left_sample;
    sfe_pkg::sample_t right_sample;
    logic            flush;

    modport source (output valid, output left_sample, output right_sample, output flush,
                    input ready);
    modport sink   (input valid, input left_sample, input right_sample, input flush,
                    output ready);
endinterface

interface sfe_result_if;
    logic            valid;
    logic            ready;
    sfe_pkg::sample_t left_out;
    sfe_pkg::sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sfe_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sfe_pkg::CFG_INDEX_W-1:0]     index;
    logic [sfe_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/sfe_history.sv */
// Delay line of past stereo pairs: memory, write pointer, fill count, tap read.
// Depends on sfe_pkg.
module sfe_history #(
    parameter int MAX_DELAY = 32768
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  sfe_pkg::pair_t       wr_pair,
    input  sfe_pkg::delay_t      delay_samples,
    output sfe_pkg::pair_t       rd_pair_reg,
    output sfe_pkg::echo_tap_t   tap_reg
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int CW = $clog2(MAX_DELAY + 1);
    localparam int XW = (CW > sfe_pkg::DELAY_W) ? CW : sfe_pkg::DELAY_W;
    localparam int RW = CW + 1;

    sfe_pkg::pair_t history_mem [MAX_DELAY];

    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] delay_clamped;
    logic [RW-1:0] wp_ext, delay_ext, rp_full;
    logic [AW-1:0] rp;
    sfe_pkg::echo_tap_t tap_next;

    // Clamp the delay to the depth of the line
    assign delay_clamped = (XW'(delay_samples) > XW'(MAX_DELAY)) ? CW'(MAX_DELAY)
                                                                 : CW'(delay_samples);

    // Read pointer trails the write pointer by the delay, modulo the depth
    assign wp_ext    = RW'(wp_reg);
    assign delay_ext = RW'(delay_clamped);
    assign rp_full   = (wp_ext >= delay_ext) ? (wp_ext - delay_ext)
                                             : (wp_ext + RW'(MAX_DELAY) - delay_ext);
    assign rp        = rp_full[AW-1:0];

    // Advance the write pointer and the saturating fill count
    assign wp_next   = (wp_reg == AW'(MAX_DELAY - 1)) ? '0 : wp_reg + AW'(1);
    assign fill_next = (fill_reg == CW'(MAX_DELAY)) ? fill_reg : fill_reg + CW'(1);

    // Entries beyond the fill count were never written and read as silence
    assign tap_next.zero_delay = (delay_clamped == '0);
    assign tap_next.hit        = (fill_reg >= delay_clamped);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
            tap_reg  <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            tap_reg  <= tap_next;
        end
    end

    // Store this beat and fetch the delayed pair; read sees the old entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            history_mem[wp_reg] <= wr_pair;
            rd_pair_reg         <= history_mem[rp];
        end
    end

endmodule

/* rtl/core/sfe_mix.sv */
// One channel of the echo mixer: scale the delayed sample, saturate, add.
// Two register stages; depends on sfe_pkg.
module sfe_mix (
    input  logic                 clk,
    input  sfe_pkg::stage_ctl_t  ctl,
    input  sfe_pkg::sample_t     cur,
    input  sfe_pkg::sample_t     hist,
    input  sfe_pkg::echo_tap_t   tap,
    input  sfe_pkg::gain_t       gain,
    output sfe_pkg::sample_t     mix_out_reg
);

    sfe_pkg::sample_t delayed;
    logic [sfe_pkg::SAMPLE_W-1:0] mag;
    sfe_pkg::prod_t   prod;

    sfe_pkg::prod_t   prod_reg;
    logic             neg_reg;
    sfe_pkg::sample_t cur_reg;

    sfe_pkg::scaled_t scaled;
    sfe_pkg::sample_t echo;
    sfe_pkg::sample_t mix_out_next;

    // Pick the echo source and take its magnitude
    always_comb
    begin
        if (tap.zero_delay)
            delayed = cur;
        else if (tap.hit)
            delayed = hist;
        else
            delayed = '0;
        mag  = delayed[sfe_pkg::SAMPLE_W-1] ? (~delayed + 1'b1) : delayed;
        prod = sfe_pkg::prod_t'(mag) * sfe_pkg::prod_t'(gain);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            prod_reg <= prod;
            neg_reg  <= delayed[sfe_pkg::SAMPLE_W-1];
            cur_reg  <= cur;
        end
    end

    // Drop the fraction, restore the sign, saturate, then wrap the sum
    always_comb
    begin
        scaled = prod_reg[sfe_pkg::PROD_W-1:sfe_pkg::GAIN_FRAC];
        if (neg_reg)
        begin
            if (scaled >= sfe_pkg::NEG_LIMIT)
                echo = sfe_pkg::SAT_NEG;
            else
                echo = ~scaled[sfe_pkg::SAMPLE_W-1:0] + 1'b1;
        end
        else
        begin
            if (scaled > sfe_pkg::POS_LIMIT)
                echo = sfe_pkg::SAT_POS;
            else
                echo = scaled[sfe_pkg::SAMPLE_W-1:0];
        end
        mix_out_next = cur_reg + echo;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s3_load)
            mix_out_reg <= mix_out_next;
    end

endmodule

/* rtl/core/stereo_feedforward_echo_top.sv */
// Pipeline: an accepted beat passes the input, product and result registers in turn.
// Throughput: one stereo beat per cycle while results are taken; the delay line memory
// takes one write and one read per beat, and each channel has one 16x16 multiply stage.
// Reset: asynchronous, active low; clears pointers, fill count, stage valids and the
// configuration registers. The delay line needs no clearing pass: unwritten entries
// read as zero.
// Top level of the stereo echo; depends on sfe_pkg, sfe_if, sfe_history, sfe_mix.
module stereo_feedforward_echo_top #(
    parameter int MAX_DELAY = 32768
) (
    input  logic                clk,
    input  logic                rst_n,
    sfe_sample_if.sink          samples,
    sfe_result_if.source        results,
    sfe_cfg_if.sink             cfg
);

    sfe_pkg::delay_t delay_reg;
    sfe_pkg::gain_t  gain_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic ready1, ready2, ready3;
    logic accept;
    sfe_pkg::stage_ctl_t ctl;

    sfe_pkg::sample_t cur_l, cur_r;
    sfe_pkg::sample_t cur_l_reg, cur_r_reg;
    sfe_pkg::pair_t   rd_pair;
    sfe_pkg::echo_tap_t tap;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            gain_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (sfe_pkg::cfg_reg_t'(cfg.index))
                sfe_pkg::REG_DELAY_SAMPLES: delay_reg <= cfg.data;
                sfe_pkg::REG_ECHO_GAIN:     gain_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage advances when the next one frees up
    assign ready3          = !s3_valid_reg || results.ready;
    assign ready2          = !s2_valid_reg || ready3;
    assign ready1          = !s1_valid_reg || ready2;
    assign samples.ready   = ready1;
    assign accept          = samples.valid && ready1;
    assign ctl.s2_load     = s1_valid_reg && ready2;
    assign ctl.s3_load     = s2_valid_reg && ready3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !ready2);
            s2_valid_reg <= ctl.s2_load || (s2_valid_reg && !ready3);
            s3_valid_reg <= ctl.s3_load || (s3_valid_reg && !results.ready);
        end
    end

    // Flush beats count as silence
    assign cur_l = samples.flush ? '0 : samples.left_sample;
    assign cur_r = samples.flush ? '0 : samples.right_sample;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_l_reg <= cur_l;
            cur_r_reg <= cur_r;
        end
    end

    sfe_history #(
        .MAX_DELAY (MAX_DELAY)
    ) u_history (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .wr_pair       ({cur_r, cur_l}),
        .delay_samples (delay_reg),
        .rd_pair_reg   (rd_pair),
        .tap_reg       (tap)
    );

    sfe_mix u_mix_left (
        .clk         (clk),
        .ctl         (ctl),
        .cur         (cur_l_reg),
        .hist        (rd_pair[sfe_pkg::SAMPLE_W-1:0]),
        .tap         (tap),
        .gain        (gain_reg),
        .mix_out_reg (results.left_out)
    );

    sfe_mix u_mix_right (
        .clk         (clk),
        .ctl         (ctl),
        .cur         (cur_r_reg),
        .hist        (rd_pair[sfe_pkg::PAIR_W-1:sfe_pkg::SAMPLE_W]),
        .tap         (tap),
        .gain        (gain_reg),
        .mix_out_reg (results.right_out)
    );

    assign results.valid = s3_valid_reg;

endmodule

/* rtl/core/sfe_checker.sv */
// Port-level checks on the stereo echo top level, and the bind that attaches them.
// Depends on sfe_pkg and the top level's interface ports.
module sfe_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input sfe_pkg::sample_t left_out,
    input sfe_pkg::sample_t right_out,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    logic [2:0] pending_reg;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Track beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_beat && !out_beat)
            pending_reg <= pending_reg + 3'd1;
        else if (out_beat && !in_beat)
            pending_reg <= pending_reg - 3'd1;
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("stalled result changed");

    // Never show a result without an accepted beat behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result without pending input");

    // No more beats in flight than the pipeline holds
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many beats in flight");

    // Input side is open whenever the output register is empty
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Register writes are never stalled
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write stalled");

endmodule

bind stereo_feedforward_echo_top sfe_checker u_sfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .left_out  (results.left_out),
    .right_out (results.right_out),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

/* tb/stereo_feedforward_echo_top_tb.sv */
// Self-checking testbench for the stereo feedforward echo block.
// Depends on sfe_pkg, the sfe_if channel interfaces and stereo_feedforward_echo_top.
`timescale 1ns / 100ps

module stereo_feedforward_echo_top_tb;

    localparam int          ECHO_DEPTH   = 32768;
    localparam int          PIPE_LATENCY = 3;
    localparam int          STALL_CYCLES = 80;
    localparam int          IDLE_PERCENT = 13;
    localparam int          RANDOM_PHASES = 6;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      TIMEOUT_NS   = 10_000_000;

    localparam logic [sfe_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = 4'hF;

    localparam sfe_pkg::gain_t  GAIN_ZERO  = 16'd0;
    localparam sfe_pkg::gain_t  GAIN_HALF  = 16'd2048;
    localparam sfe_pkg::gain_t  GAIN_UNITY = 16'd4096;
    localparam sfe_pkg::gain_t  GAIN_MAX   = 16'hFFFF;
    localparam sfe_pkg::delay_t DELAY_OVER = 16'hFFFF;

    typedef struct {
        sfe_pkg::sample_t left_out;
        sfe_pkg::sample_t right_out;
    } echo_pair_t;

    // Echo predictor plus queue of outstanding output pairs
    class echo_scoreboard;
        bit [sfe_pkg::PAIR_W-1:0] pair_history [ECHO_DEPTH];
        int unsigned     write_pos;
        sfe_pkg::delay_t delay_reg;
        sfe_pkg::gain_t  gain_reg;
        echo_pair_t      expected_q [$];
        int              failures;
        int              results_checked;

        function void set_register(logic [sfe_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [sfe_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sfe_pkg::REG_DELAY_SAMPLES: delay_reg = val;
                sfe_pkg::REG_ECHO_GAIN:     gain_reg  = val;
                default: ;
            endcase
        endfunction

        // Magnitude times gain, truncate toward zero, clamp to 16 bits
        function sfe_pkg::sample_t scale_echo(sfe_pkg::sample_t delayed);
            longint mag;
            longint prod;
            mag  = (delayed < 0) ? -longint'(delayed) : longint'(delayed);
            prod = (mag * longint'(gain_reg)) >> sfe_pkg::GAIN_FRAC;
            if (delayed < 0)
                prod = -prod;
            if (prod > 32767)
                prod = 32767;
            if (prod < -32768)
                prod = -32768;
            return sfe_pkg::sample_t'(prod);
        endfunction

        function void note_input(sfe_pkg::sample_t left, sfe_pkg::sample_t right, logic flush);
            sfe_pkg::sample_t cur_l;
            sfe_pkg::sample_t cur_r;
            sfe_pkg::sample_t del_l;
            sfe_pkg::sample_t del_r;
            int unsigned      span;
            int unsigned      rd_pos;
            echo_pair_t       pair;
            cur_l = flush ? sfe_pkg::sample_t'(0) : left;
            cur_r = flush ? sfe_pkg::sample_t'(0) : right;
            span  = (delay_reg > ECHO_DEPTH) ? ECHO_DEPTH : delay_reg;
            if (span == 0)
            begin
                del_l = cur_l;
                del_r = cur_r;
            end
            else
            begin
                rd_pos = (write_pos + ECHO_DEPTH - span) % ECHO_DEPTH;
                del_l  = sfe_pkg::sample_t'(pair_history[rd_pos][sfe_pkg::SAMPLE_W-1:0]);
                del_r  = sfe_pkg::sample_t'(
                             pair_history[rd_pos][sfe_pkg::PAIR_W-1:sfe_pkg::SAMPLE_W]);
            end
            pair.left_out  = cur_l + scale_echo(del_l);
            pair.right_out = cur_r + scale_echo(del_r);
            expected_q.push_back(pair);
            pair_history[write_pos] = {cur_r, cur_l};
            write_pos = (write_pos + 1) % ECHO_DEPTH;
        endfunction

        function void report(string what, int exp_val, int act_val);
            if (failures < MAX_REPORTS)
                $display("[%0t] %s at output %0d: expected %0d, got %0d",
                         $realtime, what, results_checked, exp_val, act_val);
            failures++;
        endfunction

        function void check_result(sfe_pkg::sample_t left, sfe_pkg::sample_t right);
            echo_pair_t pair;
            if (expected_q.size() == 0)
            begin
                report("unexpected output beat, left_out", 0, left);
            end
            else
            begin
                pair = expected_q.pop_front();
                if (left !== pair.left_out)
                    report("left_out mismatch", pair.left_out, left);
                if (right !== pair.right_out)
                    report("right_out mismatch", pair.right_out, right);
            end
            results_checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sfe_sample_if sample_ch ();
    sfe_result_if result_ch ();
    sfe_cfg_if    cfg_ch ();

    echo_scoreboard sb;

    bit stall_request;
    bit steady_stretch;
    int beats_sent;
    int flush_sent;
    int reg_writes;

    stereo_feedforward_echo_top #(
        .MAX_DELAY(ECHO_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic bit take_idle();
        return !steady_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    // Mostly full-range samples, with the corner values mixed in
    function automatic sfe_pkg::sample_t random_sample();
        if ($urandom_range(0, 7) != 0)
            return sfe_pkg::sample_t'($urandom);
        case ($urandom_range(0, 4))
            0:       return sfe_pkg::SAT_NEG;
            1:       return sfe_pkg::SAT_POS;
            2:       return -16'sd1;
            3:       return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    // Offer one beat, with a random gap ahead of it, and hold until accepted
    task automatic send_item(sfe_pkg::sample_t left, sfe_pkg::sample_t right, logic flush);
        int gap;
        gap = take_idle() ? 1 : 0;
        repeat (gap)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
        end
        @(negedge clk);
        sample_ch.valid        <= 1'b1;
        sample_ch.left_sample  <= left;
        sample_ch.right_sample <= right;
        sample_ch.flush        <= flush;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        sb.note_input(left, right, flush);
        beats_sent++;
        if (flush)
            flush_sent++;
    endtask

    task automatic send_random(int flush_percent);
        send_item(random_sample(), random_sample(), $urandom_range(0, 99) < flush_percent);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [sfe_pkg::CFG_INDEX_W-1:0] idx,
                             logic [sfe_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_register(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain the pipeline, then load both registers
    task automatic configure(sfe_pkg::delay_t delay_val, sfe_pkg::gain_t gain_val);
        drop_valid();
        wait_for_results();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        write_reg(sfe_pkg::REG_DELAY_SAMPLES, delay_val);
        write_reg(sfe_pkg::REG_ECHO_GAIN, gain_val);
    endtask

    // Signal burst followed by a flush tail of up to 32 beats that drains the echo of short delays
    task automatic run_random_phase(int phase);
        sfe_pkg::delay_t delay_val;
        sfe_pkg::gain_t  gain_val;
        int              n_signal;
        int              n_tail;
        case ($urandom_range(0, 5))
            0:       delay_val = 16'd0;
            1:       delay_val = 16'd1;
            2:       delay_val = sfe_pkg::delay_t'($urandom_range(2, 16));
            3:       delay_val = sfe_pkg::delay_t'($urandom_range(17, 600));
            4:       delay_val = sfe_pkg::delay_t'(ECHO_DEPTH);
            default: delay_val = sfe_pkg::delay_t'($urandom_range(ECHO_DEPTH + 1, 65535));
        endcase
        case ($urandom_range(0, 4))
            0:       gain_val = GAIN_ZERO;
            1:       gain_val = GAIN_UNITY;
            2:       gain_val = GAIN_MAX;
            default: gain_val = sfe_pkg::gain_t'($urandom);
        endcase
        configure(delay_val, gain_val);
        steady_stretch = (phase == 1);
        n_signal = $urandom_range(35, 50);
        for (int i = 0; i < n_signal; i++)
        begin
            // long output back-pressure while input keeps coming
            if (phase == 0 && i == 10)
                stall_request = 1'b1;
            // sender pause until the block has emptied
            if (phase == 2 && i == n_signal / 2)
            begin
                drop_valid();
                wait_for_results();
            end
            send_random(8);
        end
        n_tail = (delay_val > 32) ? 32 : delay_val;
        for (int i = 0; i < n_tail; i++)
            send_item(random_sample(), random_sample(), 1'b1);
        steady_stretch = 1'b0;
    endtask

    // Output side: random back-pressure plus one long counted hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                result_ch.ready <= !take_idle();
            end
        end
    end

    // Compare every accepted output beat
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.left_out, result_ch.right_out);
        end
    end

    initial
    begin
        int total_fail;
        sb = new;
        rst_n                  = 1'b0;
        sample_ch.valid        = 1'b0;
        sample_ch.left_sample  = '0;
        sample_ch.right_sample = '0;
        sample_ch.flush        = 1'b0;
        result_ch.ready        = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        stall_request          = 1'b0;
        steady_stretch         = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero delay, zero gain, output equals input
        send_item(16'sd1234, -16'sd1234, 1'b0);
        send_item(sfe_pkg::SAT_POS, sfe_pkg::SAT_NEG, 1'b0);

        // A write to an unused index must change nothing
        drop_valid();
        wait_for_results();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        write_reg(REG_UNUSED_TOP, 16'hFFFF);
        send_item(sfe_pkg::SAT_NEG, 16'sd77, 1'b0);

        // Zero delay at unity gain: the doubled sample wraps
        configure(16'd0, GAIN_UNITY);
        send_item(sfe_pkg::SAT_POS, sfe_pkg::SAT_NEG, 1'b0);
        send_item(16'sd16384, -16'sd16384, 1'b0);
        send_item(-16'sd1, 16'sd1, 1'b0);

        // Full gain saturates the scaled echo
        configure(16'd0, GAIN_MAX);
        send_item(sfe_pkg::SAT_NEG, sfe_pkg::SAT_POS, 1'b0);
        send_item(16'sd3, -16'sd3, 1'b0);

        // Negative products truncate toward zero; flush ignores its fields
        configure(16'd0, GAIN_HALF);
        send_item(-16'sd5, 16'sd5, 1'b0);
        send_item(-16'sd1, 16'sd1, 1'b0);
        send_item(-16'sd3, 16'sd3, 1'b0);
        send_item(-16'sd1, -16'sd1, 1'b1);

        // One-beat delay at full gain, then drain with flushes
        configure(16'd1, GAIN_MAX);
        send_item(sfe_pkg::SAT_POS, sfe_pkg::SAT_NEG, 1'b0);
        send_item(sfe_pkg::SAT_NEG, sfe_pkg::SAT_POS, 1'b0);
        send_item(16'sd1, -16'sd1, 1'b0);
        send_item(sfe_pkg::SAT_POS, sfe_pkg::SAT_POS, 1'b1);
        send_item(16'sd0, 16'sd0, 1'b1);

        configure(16'd2, GAIN_HALF);
        send_item(-16'sd5, 16'sd5, 1'b0);
        send_item(16'sd7, -16'sd7, 1'b0);
        send_item(16'sd9, 16'sd9, 1'b1);
        send_item(16'sd0, 16'sd0, 1'b1);
        send_item(16'sd0, 16'sd0, 1'b1);

        for (int p = 0; p < RANDOM_PHASES / 2; p++)
            run_random_phase(p);

        // Longest delay: the tap points at entries not yet written
        configure(sfe_pkg::delay_t'(ECHO_DEPTH), GAIN_UNITY);
        for (int i = 0; i < 40; i++)
            send_random(10);

        // Delay beyond the line depth clamps to the depth
        configure(DELAY_OVER, sfe_pkg::gain_t'($urandom));
        for (int i = 0; i < 40; i++)
            send_random(10);

        for (int p = RANDOM_PHASES / 2; p < RANDOM_PHASES; p++)
            run_random_phase(p);

        drop_valid();
        wait_for_results();
        repeat (PIPE_LATENCY * 4) @(posedge clk);

        total_fail = sb.failures + sb.pending();
        $display("Run covered %0d sample beats (%0d flush) and %0d register writes,",
                 beats_sent, flush_sent, reg_writes);
        $display("including the longest and over-range delays, %0d checked outputs, %0d errors.",
                 sb.results_checked, total_fail);
        if (total_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
